/* rtl/rc4_stream_cipher_assert.svh */
// assertion macros shared by the rc4 checker
// no dependencies
`ifndef RC4_STREAM_CIPHER_ASSERT_SVH
`define RC4_STREAM_CIPHER_ASSERT_SVH

// implication checked only outside reset
`define RC4_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition checked at every edge, reset included
`define RC4_ASSERT_ALWAYS(label, clk, cond, msg) \
    label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

/* rtl/rc4_pkg.sv */
// shared types and constants of the rc4 stream cipher
// no dependencies
package rc4_pkg;

    localparam int PERM_SIZE       = 256;
    localparam int PERM_AW         = 8;
    localparam int MAX_KEY_LEN_DEF = 256;

    localparam logic [PERM_AW-1:0] PERM_LAST = PERM_AW'(PERM_SIZE - 1);

    localparam logic ACT_KEY  = 1'b0;
    localparam logic ACT_DATA = 1'b1;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_KRD,
        ST_KRJ,
        ST_KWN,
        ST_KWJ,
        ST_PRJ,
        ST_PWI,
        ST_PWJ,
        ST_POUT
    } state_t;

    typedef struct packed {
        logic               we;
        logic [PERM_AW-1:0] waddr;
        logic [7:0]         wdata;
        logic               re;
        logic [PERM_AW-1:0] raddr;
    } perm_req_t;

endpackage

/* rtl/rc4_perm_ram.sv */
// permutation memory, one write and one read port, registered read data
// depends on rc4_pkg
module rc4_perm_ram (
    input  logic              clk,
    input  rc4_pkg::perm_req_t req,
    output logic [7:0]        rdata
);

    logic [7:0] mem_reg [rc4_pkg::PERM_SIZE];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            // write-first: a read of the entry written this cycle sees the new byte
            if (req.we && (req.waddr == req.raddr))
            begin
                rdata_reg <= req.wdata;
            end
            else
            begin
                rdata_reg <= mem_reg[req.raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rc4_key_ram.sv */
// key byte memory, one write and one read port, registered read data
// no dependencies
module rc4_key_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/rc4_ctrl.sv */
// sequencer: permutation fill, key schedule, keystream steps, result register
// depends on rc4_pkg
module rc4_ctrl #(
    parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF,
    parameter int KEY_AW      = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic               action,
    input  logic [7:0]         value,
    input  logic               last,
    output logic               result_valid,
    input  logic               result_stall,
    output logic [7:0]         cipher_byte,
    output logic [7:0]         keystream_byte,
    output logic               message_end,
    output rc4_pkg::perm_req_t perm_req,
    input  logic [7:0]         perm_rdata,
    output logic               key_we,
    output logic [KEY_AW-1:0]  key_waddr,
    output logic [7:0]         key_wdata,
    output logic               key_re,
    output logic [KEY_AW-1:0]  key_raddr,
    input  logic [7:0]         key_rdata
);

    localparam int KC_W = $clog2(MAX_KEY_LEN + 1);

    rc4_pkg::state_t state_reg, state_next;
    logic [rc4_pkg::PERM_AW-1:0] cnt_reg, cnt_next;
    logic                        sched_reg, sched_next;
    logic [KC_W-1:0]             key_count_reg, key_count_next;
    logic [7:0]                  i_reg, i_next;
    logic [7:0]                  j_reg, j_next;
    logic                        result_valid_reg, result_valid_next;

    logic [7:0]        acc_reg, acc_next;
    logic [KEY_AW-1:0] kidx_reg, kidx_next;
    logic [KC_W-1:0]   klen_reg, klen_next;
    logic [7:0]        si_reg, si_next;
    logic [7:0]        t_reg, t_next;
    logic [7:0]        val_reg, val_next;
    logic              last_reg, last_next;
    logic [7:0]        cipher_reg, keystream_reg;
    logic              end_reg;

    logic            can_take;
    logic            out_load;
    logic            out_free;
    logic [KC_W-1:0] kidx_inc;

    assign out_free = !result_valid_reg || !result_stall;
    assign kidx_inc = KC_W'(kidx_reg) + KC_W'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        sched_next     = sched_reg;
        key_count_next = key_count_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        acc_next       = acc_reg;
        kidx_next      = kidx_reg;
        klen_next      = klen_reg;
        si_next        = si_reg;
        t_next         = t_reg;
        val_next       = val_reg;
        last_next      = last_reg;
        perm_req       = '0;
        key_we         = 1'b0;
        key_re         = 1'b0;
        key_raddr      = kidx_reg;
        can_take       = 1'b0;
        out_load       = 1'b0;

        unique case (state_reg)
            rc4_pkg::ST_FILL:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = cnt_reg;
                perm_req.wdata = cnt_reg;
                cnt_next       = cnt_reg + 8'd1;
                if (cnt_reg == rc4_pkg::PERM_LAST)
                begin
                    if (sched_reg)
                    begin
                        sched_next = 1'b0;
                        acc_next   = '0;
                        kidx_next  = '0;
                        state_next = rc4_pkg::ST_KRD;
                    end
                    else
                    begin
                        state_next = rc4_pkg::ST_IDLE;
                    end
                end
            end
            rc4_pkg::ST_IDLE:
            begin
                can_take = 1'b1;
            end
            rc4_pkg::ST_KRD:
            begin
                perm_req.re    = 1'b1;
                perm_req.raddr = cnt_reg;
                key_re         = 1'b1;
                state_next     = rc4_pkg::ST_KRJ;
            end
            rc4_pkg::ST_KRJ:
            begin
                si_next        = perm_rdata;
                acc_next       = acc_reg + perm_rdata + key_rdata;
                perm_req.re    = 1'b1;
                perm_req.raddr = acc_next;
                state_next     = rc4_pkg::ST_KWN;
            end
            rc4_pkg::ST_KWN:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = cnt_reg;
                perm_req.wdata = perm_rdata;
                state_next     = rc4_pkg::ST_KWJ;
            end
            rc4_pkg::ST_KWJ:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = acc_reg;
                perm_req.wdata = si_reg;
                if (cnt_reg == rc4_pkg::PERM_LAST)
                begin
                    i_next         = '0;
                    j_next         = '0;
                    key_count_next = '0;
                    cnt_next       = '0;
                    state_next     = rc4_pkg::ST_IDLE;
                end
                else
                begin
                    // next swap step's reads overlap this write, the ram forwards
                    cnt_next       = cnt_reg + 8'd1;
                    kidx_next      = (kidx_inc == klen_reg) ? '0 : kidx_inc[KEY_AW-1:0];
                    perm_req.re    = 1'b1;
                    perm_req.raddr = cnt_next;
                    key_re         = 1'b1;
                    key_raddr      = kidx_next;
                    state_next     = rc4_pkg::ST_KRJ;
                end
            end
            rc4_pkg::ST_PRJ:
            begin
                si_next        = perm_rdata;
                j_next         = j_reg + perm_rdata;
                perm_req.re    = 1'b1;
                perm_req.raddr = j_next;
                state_next     = rc4_pkg::ST_PWI;
            end
            rc4_pkg::ST_PWI:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = i_reg;
                perm_req.wdata = perm_rdata;
                t_next         = si_reg + perm_rdata;
                state_next     = rc4_pkg::ST_PWJ;
            end
            rc4_pkg::ST_PWJ:
            begin
                perm_req.we    = 1'b1;
                perm_req.waddr = j_reg;
                perm_req.wdata = si_reg;
                perm_req.re    = 1'b1;
                perm_req.raddr = t_reg;
                state_next     = rc4_pkg::ST_POUT;
            end
            rc4_pkg::ST_POUT:
            begin
                // keystream byte sits in the ram read register until loaded
                if (out_free)
                begin
                    out_load   = 1'b1;
                    can_take   = 1'b1;
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rc4_pkg::ST_FILL;
            end
        endcase

        if (item_valid && can_take)
        begin
            if (action == rc4_pkg::ACT_DATA)
            begin
                i_next         = i_reg + 8'd1;
                perm_req.re    = 1'b1;
                perm_req.raddr = i_next;
                val_next       = value;
                last_next      = last;
                state_next     = rc4_pkg::ST_PRJ;
            end
            else
            begin
                // key bytes past the store size are dropped
                if (key_count_reg < KC_W'(MAX_KEY_LEN))
                begin
                    key_we         = 1'b1;
                    key_count_next = key_count_reg + KC_W'(1);
                end
                if (last)
                begin
                    sched_next = 1'b1;
                    cnt_next   = '0;
                    klen_next  = (key_count_next == '0) ? KC_W'(1) : key_count_next;
                    state_next = rc4_pkg::ST_FILL;
                end
                else
                begin
                    state_next = rc4_pkg::ST_IDLE;
                end
            end
        end

        if (out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= rc4_pkg::ST_FILL;
            cnt_reg          <= '0;
            sched_reg        <= 1'b0;
            key_count_reg    <= '0;
            i_reg            <= '0;
            j_reg            <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            cnt_reg          <= cnt_next;
            sched_reg        <= sched_next;
            key_count_reg    <= key_count_next;
            i_reg            <= i_next;
            j_reg            <= j_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        kidx_reg <= kidx_next;
        klen_reg <= klen_next;
        si_reg   <= si_next;
        t_reg    <= t_next;
        val_reg  <= val_next;
        last_reg <= last_next;
        if (out_load)
        begin
            keystream_reg <= perm_rdata;
            cipher_reg    <= val_reg ^ perm_rdata;
            end_reg       <= last_reg;
        end
    end

    assign item_stall     = !can_take;
    assign result_valid   = result_valid_reg;
    assign cipher_byte    = cipher_reg;
    assign keystream_byte = keystream_reg;
    assign message_end    = end_reg;
    assign key_waddr      = key_count_reg[KEY_AW-1:0];
    assign key_wdata      = value;

endmodule

/* rtl/rc4_stream_cipher.sv */
// rc4 data byte: result registered after the steps below; items stall until it is loaded
// (four steps on the single permutation memory: read i, read j, write i, write j/read t)
// key byte without last: taken without stall; key byte with last: items stall during the
// identity fill, one priming read, then 256 swap steps (read, write of S[i], write of S[j])
// reset: async active low, then an identity fill of the permutation with items stalled
// top level: permutation memory, key memory and sequencer; depends on rc4_pkg
module rc4_stream_cipher #(
    parameter int MAX_KEY_LEN = rc4_pkg::MAX_KEY_LEN_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    output logic       item_stall,
    input  logic       action,
    input  logic [7:0] value,
    input  logic       last,
    output logic       result_valid,
    input  logic       result_stall,
    output logic [7:0] cipher_byte,
    output logic [7:0] keystream_byte,
    output logic       message_end
);

    localparam int KEY_AW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;

    rc4_pkg::perm_req_t perm_req;
    logic [7:0]         perm_rdata;
    logic               key_we;
    logic [KEY_AW-1:0]  key_waddr;
    logic [7:0]         key_wdata;
    logic               key_re;
    logic [KEY_AW-1:0]  key_raddr;
    logic [7:0]         key_rdata;

    rc4_ctrl #(
        .MAX_KEY_LEN (MAX_KEY_LEN),
        .KEY_AW      (KEY_AW)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_stall     (item_stall),
        .action         (action),
        .value          (value),
        .last           (last),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .cipher_byte    (cipher_byte),
        .keystream_byte (keystream_byte),
        .message_end    (message_end),
        .perm_req       (perm_req),
        .perm_rdata     (perm_rdata),
        .key_we         (key_we),
        .key_waddr      (key_waddr),
        .key_wdata      (key_wdata),
        .key_re         (key_re),
        .key_raddr      (key_raddr),
        .key_rdata      (key_rdata)
    );

    rc4_perm_ram u_perm_ram (
        .clk   (clk),
        .req   (perm_req),
        .rdata (perm_rdata)
    );

    rc4_key_ram #(
        .DEPTH (MAX_KEY_LEN),
        .AW    (KEY_AW)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (key_wdata),
        .re    (key_re),
        .raddr (key_raddr),
        .rdata (key_rdata)
    );

endmodule

/* rtl/rc4_checker.sv */
// port-level checks of the rc4 stream cipher, bound to the top level
// depends on rc4_pkg and rc4_stream_cipher_assert.svh
`include "rc4_stream_cipher_assert.svh"

module rc4_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_stall,
    input logic       action,
    input logic       last,
    input logic       result_valid,
    input logic       result_stall,
    input logic [7:0] cipher_byte,
    input logic [7:0] keystream_byte,
    input logic       message_end
);

    logic data_acc;
    logic sched_acc;

    assign data_acc  = item_valid && !item_stall && (action == rc4_pkg::ACT_DATA);
    assign sched_acc = item_valid && !item_stall && (action == rc4_pkg::ACT_KEY) && last;

    // in reset the block is filling the permutation and takes no item
    `RC4_ASSERT_ALWAYS(a_reset_quiet, clk, rst_n || item_stall, "item taken in reset")

    // a data item keeps the input stalled for its three memory steps
    `RC4_ASSERT_IMPL(a_data_busy, clk, rst_n, data_acc, ##1 item_stall ##1 item_stall ##1 item_stall, "item taken during keystream step")

    // the last key byte starts the schedule
    `RC4_ASSERT_IMPL(a_sched_busy, clk, rst_n, sched_acc, ##1 item_stall, "item taken at schedule start")

    `RC4_ASSERT_IMPL(a_result_hold, clk, rst_n, result_valid && result_stall, ##1 (result_valid && $stable(cipher_byte) && $stable(keystream_byte) && $stable(message_end)), "stalled result changed")

endmodule

bind rc4_stream_cipher rc4_checker u_checker (.*);
